// ----- hw/rtl/havf_pkg.sv -----
// Shared types and constants for the HTML attribute value finder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package havf_pkg;

   localparam int TEXT_BYTE_W   = 8;
   localparam int SEEK_WORD_W   = 64;
   localparam int SEEK_LEN_W    = 5;
   localparam int SEEK_BYTES    = 16;
   localparam int OFFSET_W      = 12;
   localparam int LENGTH_W      = 13;
   localparam int CSR_INDEX_W   = 2;
   localparam int PHASE_W       = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEEK_NAME_LOW    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEEK_NAME_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEEK_NAME_LENGTH = 2'd2;

   localparam logic [TEXT_BYTE_W-1:0] CHAR_EQUAL  = 8'h3D;
   localparam logic [TEXT_BYTE_W-1:0] CHAR_DQUOTE = 8'h22;
   localparam logic [TEXT_BYTE_W-1:0] CHAR_SQUOTE = 8'h27;
   localparam logic [TEXT_BYTE_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [TEXT_BYTE_W-1:0] CHAR_TAB    = 8'h09;
   localparam logic [TEXT_BYTE_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [TEXT_BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [TEXT_BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [TEXT_BYTE_W-1:0] CASE_OFFSET  = 8'h20;

   // One classified text byte, as it travels from the front end to the parser.
   typedef struct packed {
      logic [TEXT_BYTE_W-1:0] folded;
      logic                   is_space;
      logic                   is_equal;
      logic                   is_dquote;
      logic                   is_squote;
      logic                   final_byte;
   } havf_class_type;

   // Configuration seen by the parser.
   typedef struct packed {
      logic [SEEK_WORD_W-1:0] seek_name_low;
      logic [SEEK_WORD_W-1:0] seek_name_high;
      logic [SEEK_LEN_W-1:0]  seek_name_length;
   } havf_cfg_type;

endpackage

// ----- hw/rtl/havf_req_if.sv -----
// Input channel interface: one raw text byte per transfer.
// Depends on havf_pkg for field widths.
`timescale 1ns / 1ps

interface havf_req_if
   import havf_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic [TEXT_BYTE_W-1:0] text_byte;
   logic                   final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// ----- hw/rtl/havf_rsp_if.sv -----
// Result channel interface: one lookup result per transfer.
// Depends on havf_pkg for field widths.
`timescale 1ns / 1ps

interface havf_rsp_if
   import havf_pkg::*;
;
   logic                valid;
   logic                ready;
   logic                match_found;
   logic                value_present;
   logic [OFFSET_W-1:0] value_offset;
   logic [LENGTH_W-1:0] value_length;
   logic                text_too_long;

   modport source (output valid, output match_found, output value_present,
                   output value_offset, output value_length, output text_too_long,
                   input ready);
   modport sink   (input valid, input match_found, input value_present,
                   input value_offset, input value_length, input text_too_long,
                   output ready);
endinterface

// ----- hw/rtl/havf_front.sv -----
// Front end: takes text bytes from the input channel and classifies them.
// Depends on havf_pkg and havf_req_if.
`timescale 1ns / 1ps

module havf_front
   import havf_pkg::*;
(
   havf_req_if.sink        req,
   output logic            push_valid,
   output havf_class_type  push_item,
   input  logic            push_ready
);

   logic [TEXT_BYTE_W-1:0] raw;

   assign raw        = req.text_byte;
   assign req.ready  = push_ready;
   assign push_valid = req.valid;

   always_comb begin
      push_item.is_space   = (raw == CHAR_SPACE) || ((raw >= CHAR_TAB) && (raw <= CHAR_CR));
      push_item.is_equal   = (raw == CHAR_EQUAL);
      push_item.is_dquote  = (raw == CHAR_DQUOTE);
      push_item.is_squote  = (raw == CHAR_SQUOTE);
      push_item.final_byte = req.final_byte;
      if ((raw >= CHAR_UPPER_A) && (raw <= CHAR_UPPER_Z)) begin
         push_item.folded = raw + CASE_OFFSET;
      end else begin
         push_item.folded = raw;
      end
   end

endmodule

// ----- hw/rtl/havf_queue.sv -----
// Short FIFO of classified bytes between the front end and the parser.
// Depends on havf_pkg for the entry type.
`timescale 1ns / 1ps

module havf_queue
   import havf_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  havf_class_type push_item,
   output logic           push_ready,
   output logic           pop_valid,
   output havf_class_type pop_item,
   input  logic           pop_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   havf_class_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/havf_parser.sv -----
// Back end: attribute parse state machine, name compare, match latch and result register.
// Depends on havf_pkg and havf_rsp_if.
`timescale 1ns / 1ps

module havf_parser
   import havf_pkg::*;
#(
   parameter int MAX_TEXT_BYTES = 4096,
   parameter int NAME_BYTES     = 16
)
(
   input  logic           clock,
   input  logic           reset,
   input  havf_cfg_type   cfg,
   input  logic           item_valid,
   input  havf_class_type item,
   output logic           item_ready,
   havf_rsp_if.source     rsp
);

   localparam int POS_W = $clog2(MAX_TEXT_BYTES + 1);
   localparam int IDX_W = $clog2(NAME_BYTES + 1);
   localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_TEXT_BYTES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_TEXT_BYTES - 1);

   localparam logic [PHASE_W-1:0] PH_LEAD         = 3'd0;
   localparam logic [PHASE_W-1:0] PH_NAME         = 3'd1;
   localparam logic [PHASE_W-1:0] PH_AFTER_NAME   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_BEFORE_VALUE = 3'd3;
   localparam logic [PHASE_W-1:0] PH_QUOTED       = 3'd4;
   localparam logic [PHASE_W-1:0] PH_UNQUOTED     = 3'd5;
   localparam logic [PHASE_W-1:0] PH_AFTER_QUOTE  = 3'd6;

   function automatic logic [POS_W-1:0] span(input logic [POS_W-1:0] first,
                                              input logic [POS_W-1:0] last);
      return (last > first) ? last - first : '0;
   endfunction

   // Parse state.
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   name_start_ff, name_start_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               still_eq_ff, still_eq_in;
   logic               quote_single_ff, quote_single_in;
   logic [POS_W-1:0]   value_start_ff, value_start_in;
   logic               match_ff, match_in;
   logic               lat_has_value_ff, lat_has_value_in;
   logic [POS_W-1:0]   lat_offset_ff, lat_offset_in;
   logic [POS_W-1:0]   lat_length_ff, lat_length_in;
   logic               overflow_ff, overflow_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_match_ff, rsp_match_in;
   logic                rsp_present_ff, rsp_present_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [LENGTH_W-1:0] rsp_length_ff, rsp_length_in;
   logic                rsp_long_ff, rsp_long_in;

   logic [TEXT_BYTE_W-1:0] sought [SEEK_BYTES];
   logic [IDX_W-1:0]       slen;
   logic                   step;
   logic [POS_W-1:0]       here, next_pos;
   logic                   begin_eq, cont_eq;
   logic [IDX_W-1:0]       begin_idx, cont_idx;
   logic                   fin1;
   logic                   fin1_has_value;
   logic [POS_W-1:0]       fin1_offset, fin1_length;
   logic                   fin2, fin2_ok;
   logic                   fin2_has_value;
   logic [POS_W-1:0]       fin2_offset, fin2_length;
   logic [PHASE_W-1:0]     ph1;
   logic [POS_W-1:0]       ns1, vs1;
   logic [IDX_W-1:0]       idx1;
   logic                   eq1, qs1, m1, lh1;
   logic [POS_W-1:0]       lo1, ll1;
   logic                   m2, lh2;
   logic [POS_W-1:0]       lo2, ll2, lo_sat;
   logic                   quote_close;

   always_comb begin
      for (int k = 0; k < SEEK_BYTES; k++) begin
         if (k < 8) begin
            sought[k] = cfg.seek_name_low[8*k +: 8];
         end else begin
            sought[k] = cfg.seek_name_high[8*(k-8) +: 8];
         end
      end
   end

   assign slen = (cfg.seek_name_length > SEEK_LEN_W'(NAME_BYTES)) ?
                 IDX_W'(NAME_BYTES) : IDX_W'(cfg.seek_name_length);

   // A final byte needs the result register; other bytes never wait.
   assign item_ready = !item.final_byte || !rsp_valid_ff || rsp.ready;
   assign step       = item_valid && item_ready;

   assign here     = pos_ff;
   assign next_pos = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + POS_W'(1);

   // Name compare for the first byte of a new name and for a following byte.
   always_comb begin
      begin_eq  = (slen != '0) && (item.folded == sought[0]);
      begin_idx = (slen != '0) ? IDX_W'(1) : '0;
      if (cmp_idx_ff >= slen) begin
         cont_eq  = 1'b0;
         cont_idx = cmp_idx_ff;
      end else begin
         cont_eq  = still_eq_ff && (item.folded == sought[4'(cmp_idx_ff)]);
         cont_idx = cmp_idx_ff + IDX_W'(1);
      end
   end

   assign quote_close = quote_single_ff ? item.is_squote : item.is_dquote;

   always_comb begin
      ph1            = phase_ff;
      ns1            = name_start_ff;
      idx1           = cmp_idx_ff;
      eq1            = still_eq_ff;
      qs1            = quote_single_ff;
      vs1            = value_start_ff;
      fin1           = 1'b0;
      fin1_has_value = 1'b0;
      fin1_offset    = name_start_ff;
      fin1_length    = '0;

      case (phase_ff)
         PH_LEAD, PH_AFTER_QUOTE, PH_AFTER_NAME: begin
            if (phase_ff == PH_AFTER_NAME && item.is_equal) begin
               ph1 = PH_BEFORE_VALUE;
            end else if (item.is_space) begin
               if (phase_ff != PH_AFTER_NAME) begin
                  ph1 = PH_LEAD;
               end
            end else begin
               // An attribute without a value ends when the next name begins.
               fin1 = (phase_ff == PH_AFTER_NAME);
               ns1  = here;
               if (item.is_equal) begin
                  idx1 = '0;
                  eq1  = 1'b1;
                  ph1  = PH_BEFORE_VALUE;
               end else begin
                  idx1 = begin_idx;
                  eq1  = begin_eq;
                  ph1  = PH_NAME;
               end
            end
         end
         PH_NAME: begin
            if (item.is_space) begin
               ph1 = PH_AFTER_NAME;
            end else if (item.is_equal) begin
               ph1 = PH_BEFORE_VALUE;
            end else begin
               idx1 = cont_idx;
               eq1  = cont_eq;
            end
         end
         PH_BEFORE_VALUE: begin
            if (item.is_dquote || item.is_squote) begin
               qs1 = item.is_squote;
               vs1 = next_pos;
               ph1 = PH_QUOTED;
            end else if (!item.is_space) begin
               vs1 = here;
               ph1 = PH_UNQUOTED;
            end
         end
         PH_QUOTED: begin
            if (quote_close) begin
               fin1           = 1'b1;
               fin1_has_value = 1'b1;
               fin1_offset    = value_start_ff;
               fin1_length    = span(value_start_ff, here);
               ph1            = PH_AFTER_QUOTE;
            end
         end
         default: begin
            // Unquoted value, ended by whitespace.
            if (item.is_space) begin
               fin1           = 1'b1;
               fin1_has_value = 1'b1;
               fin1_offset    = value_start_ff;
               fin1_length    = span(value_start_ff, here);
               ph1            = PH_LEAD;
            end
         end
      endcase

      m1  = match_ff;
      lh1 = lat_has_value_ff;
      lo1 = lat_offset_ff;
      ll1 = lat_length_ff;
      if (fin1 && !match_ff && still_eq_ff && (cmp_idx_ff == slen)) begin
         m1  = 1'b1;
         lh1 = fin1_has_value;
         lo1 = fin1_offset;
         ll1 = fin1_length;
      end
   end

   // Close the attribute that is still open when the text ends.
   always_comb begin
      fin2           = 1'b1;
      fin2_ok        = eq1 && (idx1 == slen);
      fin2_has_value = 1'b1;
      fin2_offset    = next_pos;
      fin2_length    = '0;
      case (ph1)
         PH_LEAD: begin
            // Trailing whitespace forms an empty name.
            fin2_ok        = (slen == '0);
            fin2_has_value = 1'b0;
         end
         PH_NAME, PH_AFTER_NAME: begin
            fin2_has_value = 1'b0;
            fin2_offset    = ns1;
         end
         PH_BEFORE_VALUE: begin
            fin2_offset = next_pos;
         end
         PH_AFTER_QUOTE: begin
            fin2 = 1'b0;
         end
         default: begin
            fin2_offset = vs1;
            fin2_length = span(vs1, next_pos);
         end
      endcase

      m2  = m1;
      lh2 = lh1;
      lo2 = lo1;
      ll2 = ll1;
      if (fin2 && fin2_ok && !m1) begin
         m2  = 1'b1;
         lh2 = fin2_has_value;
         lo2 = fin2_offset;
         ll2 = fin2_length;
      end
      lo_sat = (lo2 >= POS_MAX) ? POS_LAST : lo2;
   end

   always_comb begin
      overflow_in      = overflow_ff || (pos_ff == POS_MAX);
      phase_in         = phase_ff;
      pos_in           = pos_ff;
      name_start_in    = name_start_ff;
      cmp_idx_in       = cmp_idx_ff;
      still_eq_in      = still_eq_ff;
      quote_single_in  = quote_single_ff;
      value_start_in   = value_start_ff;
      match_in         = match_ff;
      lat_has_value_in = lat_has_value_ff;
      lat_offset_in    = lat_offset_ff;
      lat_length_in    = lat_length_ff;
      if (step) begin
         if (item.final_byte) begin
            phase_in         = PH_LEAD;
            pos_in           = '0;
            name_start_in    = '0;
            cmp_idx_in       = '0;
            still_eq_in      = 1'b1;
            quote_single_in  = 1'b0;
            value_start_in   = '0;
            match_in         = 1'b0;
            lat_has_value_in = 1'b0;
            lat_offset_in    = '0;
            lat_length_in    = '0;
            overflow_in      = 1'b0;
         end else begin
            phase_in         = ph1;
            pos_in           = next_pos;
            name_start_in    = ns1;
            cmp_idx_in       = idx1;
            still_eq_in      = eq1;
            quote_single_in  = qs1;
            value_start_in   = vs1;
            match_in         = m1;
            lat_has_value_in = lh1;
            lat_offset_in    = lo1;
            lat_length_in    = ll1;
         end
      end else begin
         overflow_in = overflow_ff;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_match_in   = rsp_match_ff;
      rsp_present_in = rsp_present_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_length_in  = rsp_length_ff;
      rsp_long_in    = rsp_long_ff;
      if (step && item.final_byte) begin
         rsp_valid_in   = 1'b1;
         rsp_match_in   = m2;
         rsp_present_in = m2 && lh2;
         rsp_offset_in  = m2 ? OFFSET_W'(lo_sat) : '0;
         rsp_length_in  = m2 ? LENGTH_W'(ll2) : '0;
         rsp_long_in    = overflow_ff || (pos_ff == POS_MAX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_LEAD;
         pos_ff           <= '0;
         name_start_ff    <= '0;
         cmp_idx_ff       <= '0;
         still_eq_ff      <= 1'b1;
         quote_single_ff  <= 1'b0;
         value_start_ff   <= '0;
         match_ff         <= 1'b0;
         lat_has_value_ff <= 1'b0;
         lat_offset_ff    <= '0;
         lat_length_ff    <= '0;
         overflow_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         pos_ff           <= pos_in;
         name_start_ff    <= name_start_in;
         cmp_idx_ff       <= cmp_idx_in;
         still_eq_ff      <= still_eq_in;
         quote_single_ff  <= quote_single_in;
         value_start_ff   <= value_start_in;
         match_ff         <= match_in;
         lat_has_value_ff <= lat_has_value_in;
         lat_offset_ff    <= lat_offset_in;
         lat_length_ff    <= lat_length_in;
         overflow_ff      <= overflow_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_match_ff   <= rsp_match_in;
      rsp_present_ff <= rsp_present_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_length_ff  <= rsp_length_in;
      rsp_long_ff    <= rsp_long_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.match_found   = rsp_match_ff;
   assign rsp.value_present = rsp_present_ff;
   assign rsp.value_offset  = rsp_offset_ff;
   assign rsp.value_length  = rsp_length_ff;
   assign rsp.text_too_long = rsp_long_ff;

endmodule

// ----- hw/rtl/html_attribute_value_finder.sv -----
// HTML attribute value finder, top level. Throughput: one text byte per cycle while no final byte waits.
// The final byte of a text passes through the byte queue, and its result then through the
// parser's result register.
// The parse state machine consumes one queued byte per cycle; only a final byte waits,
// and only while the previous result has not been taken.
// Reset (synchronous, active high) clears the parse state, the queue, the result valid
// and the configuration registers to zero.
`timescale 1ns / 1ps

module html_attribute_value_finder
   import havf_pkg::*;
#(
   parameter int MAX_TEXT_BYTES = 4096,
   parameter int NAME_BYTES     = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   havf_req_if.sink               req_chan,
   havf_rsp_if.source             rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SEEK_WORD_W-1:0] csr_write_data
);

   // The front end classifies each byte as it is transferred in (whitespace, equals sign,
   // quotes, and the lower-case fold of letters) and pushes it into a short queue. The
   // parser pops one classified byte per cycle unless a final byte waits on a stalled result
   // channel; the front then keeps taking text only until the queue is full.
   localparam int QUEUE_DEPTH = 2;

   havf_cfg_type   cfg_ff, cfg_in;
   logic           push_valid, push_ready;
   havf_class_type push_item;
   logic           pop_valid, pop_ready;
   havf_class_type pop_item;

   // Configuration registers. Writes to an index beyond the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SEEK_NAME_LOW:    cfg_in.seek_name_low    = csr_write_data;
            CSR_SEEK_NAME_HIGH:   cfg_in.seek_name_high   = csr_write_data;
            CSR_SEEK_NAME_LENGTH: cfg_in.seek_name_length = csr_write_data[SEEK_LEN_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   havf_front u_front (
      .req        (req_chan),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   havf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // The parser keeps its position counters saturated at MAX_TEXT_BYTES and flags texts
   // that run past it; reported offsets never exceed MAX_TEXT_BYTES-1.
   havf_parser #(
      .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
      .NAME_BYTES     (NAME_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (pop_valid),
      .item       (pop_item),
      .item_ready (pop_ready),
      .rsp        (rsp_chan)
   );

endmodule
